// ===== design/text_mode_glyph_fetch_unit_assert.svh =====
// assertion macros for the glyph fetch unit
`ifndef TEXT_MODE_GLYPH_FETCH_UNIT_ASSERT_SVH
`define TEXT_MODE_GLYPH_FETCH_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TMGF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define TMGF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define TMGF_ASSERT(lbl, prop, msg)
`define TMGF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== design/tmgf_pkg.sv =====
`timescale 1ns / 1ps
package tmgf_pkg;

  localparam int COLUMNS_DEF        = 20;
  localparam int ACTIVE_LINES_DEF   = 480;
  localparam int GLYPH_ROWS         = 8;
  localparam int LINES_PER_TEXT_ROW = 16;

  localparam logic [7:0] BACK_PORCH_RESET = 8'd35;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_HSYNC = 2'd1;
  localparam logic [1:0] CMD_VSYNC = 2'd2;

  typedef struct packed {
    logic [7:0] code;
    logic [2:0] grow;
    logic [4:0] col;
    logic       last;
  } glyph_t;

endpackage

// ===== design/tmgf_cmd_if.sv =====
`timescale 1ns / 1ps
interface tmgf_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [4:0] cell_row;
  logic [4:0] cell_column;
  logic [7:0] cell_char;

  modport source (output valid, command, cell_row, cell_column, cell_char, input ready);
  modport sink   (input valid, command, cell_row, cell_column, cell_char, output ready);
endinterface

// ===== design/tmgf_glyph_if.sv =====
`timescale 1ns / 1ps
interface tmgf_glyph_if;
  logic       valid;
  logic       ready;
  logic [7:0] glyph_code;
  logic [2:0] glyph_row;
  logic [4:0] column_index;
  logic       last_of_line;

  modport source (output valid, glyph_code, glyph_row, column_index, last_of_line,
                  input ready);
  modport sink   (input valid, glyph_code, glyph_row, column_index, last_of_line,
                  output ready);
endinterface

// ===== design/tmgf_cfg_if.sv =====
`timescale 1ns / 1ps
interface tmgf_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] back_porch_lines;

  modport source (output valid, back_porch_lines, input ready);
  modport sink   (input valid, back_porch_lines, output ready);
endinterface

// ===== design/text_mode_glyph_fetch_unit.sv =====
`timescale 1ns / 1ps
// write, vsync and idle hsync beats are taken without holding the input
// active hsync holds input for COLUMNS store reads, one per cycle unless stalled
// beats pass FETCH state, store read register, output queue; one per cycle if ready
// reset zeroes the character store's TEXT_ROWS * COLUMNS entries (600 by default),
// input not ready meanwhile; back porch register resets to 35, counters to zero
`include "text_mode_glyph_fetch_unit_assert.svh"
module text_mode_glyph_fetch_unit #(
  parameter int COLUMNS      = tmgf_pkg::COLUMNS_DEF,
  parameter int ACTIVE_LINES = tmgf_pkg::ACTIVE_LINES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tmgf_cmd_if.sink    cmd_i,
  tmgf_cfg_if.sink    cfg_i,
  tmgf_glyph_if.source glyph_o
);

  localparam int TEXT_ROWS = ACTIVE_LINES / tmgf_pkg::LINES_PER_TEXT_ROW;
  localparam int DEPTH     = TEXT_ROWS * COLUMNS;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BW        = $clog2(DEPTH + 1);
  localparam int CW        = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int LW        = $clog2(ACTIVE_LINES + 1);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FETCH = 2'b10
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   col_q, col_d;
  logic [LW-1:0]   line_q, line_d;
  logic [BW-1:0]   base_q, base_d;
  logic [7:0]      porch_q, porch_d;
  logic [7:0]      bpl_q;

  logic            clr_busy;
  logic            cmd_accept;
  logic            cell_ok;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [BW:0]     rd_sum;
  logic [AW-1:0]   raddr;
  logic [7:0]      rdata;
  logic            last_col;
  logic            line_active;
  logic [LW-1:0]   line_inc;

  logic            pend_q;
  tmgf_pkg::glyph_t pend_meta_q;
  tmgf_pkg::glyph_t meta;
  tmgf_pkg::glyph_t push_data;
  tmgf_pkg::glyph_t slot_q [2];
  logic [1:0]      cnt_q;
  logic [1:0]      occ;
  logic            pop;
  logic            issue;

  // config register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpl_q <= tmgf_pkg::BACK_PORCH_RESET;
    end else if (cfg_i.valid) begin
      bpl_q <= cfg_i.back_porch_lines;
    end
  end

  assign cmd_i.ready = (state_q == ST_IDLE) && !clr_busy;
  assign cmd_accept  = cmd_i.valid && cmd_i.ready;

  assign cell_ok = (int'(cmd_i.cell_row) < TEXT_ROWS) && (int'(cmd_i.cell_column) < COLUMNS);
  assign we      = cmd_accept && (cmd_i.command == tmgf_pkg::CMD_WRITE) && cell_ok;
  assign waddr   = AW'(int'(cmd_i.cell_row) * COLUMNS + int'(cmd_i.cell_column));

  assign rd_sum      = {1'b0, base_q} + (BW + 1)'(col_q);
  assign raddr       = rd_sum[AW-1:0];
  assign last_col    = (int'(col_q) == COLUMNS - 1);
  assign line_active = (int'(line_q) < ACTIVE_LINES);
  assign line_inc    = line_q + LW'(1);

  // two-slot output queue plus one read in flight, never more than two beats owed
  assign occ   = cnt_q + {1'b0, pend_q};
  assign pop   = glyph_o.valid && glyph_o.ready;
  assign issue = (state_q == ST_FETCH) && ((occ < 2'd2) || ((occ == 2'd2) && pop));

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    line_d  = line_q;
    base_d  = base_q;
    porch_d = porch_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_accept) begin
          case (cmd_i.command)
            tmgf_pkg::CMD_HSYNC: begin
              if (porch_q != 8'd0) begin
                porch_d = porch_q - 8'd1;
              end else if (line_active) begin
                state_d = ST_FETCH;
                col_d   = '0;
              end
            end
            tmgf_pkg::CMD_VSYNC: begin
              line_d  = '0;
              base_d  = '0;
              porch_d = bpl_q;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FETCH: begin
        if (issue) begin
          if (last_col) begin
            state_d = ST_IDLE;
            line_d  = line_inc;
            // double-height text rows: next row base every 16 scan lines
            if (line_inc[3:0] == 4'd0) begin
              base_d = base_q + BW'(COLUMNS);
            end
          end else begin
            col_d = col_q + CW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      col_q   <= '0;
      line_q  <= '0;
      base_q  <= '0;
      porch_q <= 8'd0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      line_q  <= line_d;
      base_q  <= base_d;
      porch_q <= porch_d;
    end
  end

  tmgf_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (cmd_i.cell_char),
    .re_i    (issue),
    .raddr_i (raddr),
    .rdata_o (rdata),
    .busy_o  (clr_busy)
  );

  always_comb begin
    meta      = '0;
    meta.grow = line_q[3:1];
    meta.col  = 5'(col_q);
    meta.last = last_col;
    push_data      = pend_meta_q;
    push_data.code = rdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      pend_q <= issue;
      cnt_q  <= cnt_q + {1'b0, pend_q} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      pend_meta_q <= meta;
    end
    if (pop) begin
      if (cnt_q == 2'd2) begin
        slot_q[0] <= slot_q[1];
        if (pend_q) begin
          slot_q[1] <= push_data;
        end
      end else if (pend_q) begin
        slot_q[0] <= push_data;
      end
    end else if (pend_q) begin
      slot_q[cnt_q[0]] <= push_data;
    end
  end

  assign glyph_o.valid        = (cnt_q != 2'd0);
  assign glyph_o.glyph_code   = slot_q[0].code;
  assign glyph_o.glyph_row    = slot_q[0].grow;
  assign glyph_o.column_index = slot_q[0].col;
  assign glyph_o.last_of_line = slot_q[0].last;

  `TMGF_ASSERT(a_owed_beats, ({1'b0, cnt_q} + {2'b0, pend_q}) <= 3'd2, "output queue overrun")
  `TMGF_ASSERT(a_no_read_in_clear, issue |-> !clr_busy, "store read during clearing sweep")
  `TMGF_ASSERT(a_last_col, glyph_o.valid && glyph_o.last_of_line |-> glyph_o.column_index == 5'(COLUMNS - 1), "line end on wrong column")
  `TMGF_ASSERT(a_col_step, issue && !last_col |=> int'(col_q) == int'($past(col_q)) + 1, "column counter skipped")

endmodule

// ===== design/tmgf_store.sv =====
`timescale 1ns / 1ps
module tmgf_store #(
  parameter int DEPTH = 600,
  parameter int AW    = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o,
  output logic          busy_o
);

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata_q;
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  // zero sweep after reset, one entry a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= 8'd0;
    end else if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clr_busy_q;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  localparam int COLS         = tmgf_pkg::COLUMNS_DEF;
  localparam int LINES        = tmgf_pkg::ACTIVE_LINES_DEF;
  localparam int TEXT_ROWS    = LINES / tmgf_pkg::LINES_PER_TEXT_ROW;
  localparam int QUIET_CYCLES = 32;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_LIMIT  = 20000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // character store and scan counters, tracked beat by beat
  class glyph_scoreboard;
    logic [7:0]  char_mem [TEXT_ROWS * COLS];
    logic [7:0]  porch_setting;
    logic [7:0]  porch_left;
    int unsigned line_num;
    int unsigned text_row;
    tmgf_pkg::glyph_t fetch_q [$];
    int          errors;
    int          n_commands;
    int          n_writes;
    int          n_vsyncs;
    int          n_porch;
    int          n_lines;
    int          n_checked;

    function new();
      foreach (char_mem[i]) char_mem[i] = 8'h00;
      porch_setting = tmgf_pkg::BACK_PORCH_RESET;
      porch_left = 8'd0;
      line_num = 0;
      text_row = 0;
      errors = 0;
      n_commands = 0;
      n_writes = 0;
      n_vsyncs = 0;
      n_porch = 0;
      n_lines = 0;
      n_checked = 0;
    endfunction

    function void set_back_porch(logic [7:0] lines_in);
      porch_setting = lines_in;
    endfunction

    function int pending();
      return fetch_q.size();
    endfunction

    function void note_command(logic [1:0] op, logic [4:0] row, logic [4:0] col,
                               logic [7:0] ch);
      tmgf_pkg::glyph_t g;
      n_commands++;
      case (op)
        tmgf_pkg::CMD_WRITE: begin
          // writes outside the 30 x 20 grid are dropped
          if (row < TEXT_ROWS && col < COLS) begin
            char_mem[int'(row) * COLS + int'(col)] = ch;
            n_writes++;
          end
        end
        tmgf_pkg::CMD_HSYNC: begin
          if (porch_left != 8'd0) begin
            porch_left = porch_left - 8'd1;
            n_porch++;
          end else if (line_num < LINES) begin
            for (int c = 0; c < COLS; c++) begin
              g.code = (text_row < TEXT_ROWS) ? char_mem[text_row * COLS + c] : 8'h00;
              g.grow = 3'((line_num >> 1) % tmgf_pkg::GLYPH_ROWS);
              g.col  = 5'(c);
              g.last = (c == COLS - 1);
              fetch_q.push_back(g);
            end
            line_num++;
            n_lines++;
            // double height text: next text row every 16 scan lines
            if (line_num % tmgf_pkg::LINES_PER_TEXT_ROW == 0) text_row++;
          end
        end
        tmgf_pkg::CMD_VSYNC: begin
          line_num = 0;
          text_row = 0;
          porch_left = porch_setting;
          n_vsyncs++;
        end
        default: ;
      endcase
    endfunction

    function void check_fetch(tmgf_pkg::glyph_t got);
      tmgf_pkg::glyph_t want;
      if (fetch_q.size() == 0) begin
        $error("fetch beat with nothing expected: code %0d row %0d column %0d last %0d",
               got.code, got.grow, got.col, got.last);
        errors++;
        return;
      end
      want = fetch_q.pop_front();
      n_checked++;
      if (got.code !== want.code) begin
        $error("glyph_code expected %0d actual %0d", want.code, got.code);
        errors++;
      end
      if (got.grow !== want.grow) begin
        $error("glyph_row expected %0d actual %0d", want.grow, got.grow);
        errors++;
      end
      if (got.col !== want.col) begin
        $error("column_index expected %0d actual %0d", want.col, got.col);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last_of_line expected %0d actual %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  int   idle_pct;
  int   stall_pct;
  int   hold_len;
  int   hold_req;
  int   hold_seen;
  int   hold_left;
  int   cycle_count;

  glyph_scoreboard board = new();

  tmgf_cmd_if   cmd_bus ();
  tmgf_cfg_if   cfg_bus ();
  tmgf_glyph_if glyph_bus ();

  text_mode_glyph_fetch_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_bus),
    .cfg_i   (cfg_bus),
    .glyph_o (glyph_bus)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  // beat monitor and receiver side
  always @(posedge clk_i) begin
    if (glyph_bus.valid && glyph_bus.ready)
      board.check_fetch(tmgf_pkg::glyph_t'{glyph_bus.glyph_code, glyph_bus.glyph_row,
                                           glyph_bus.column_index, glyph_bus.last_of_line});
    if (cmd_bus.valid && cmd_bus.ready)
      board.note_command(cmd_bus.command, cmd_bus.cell_row, cmd_bus.cell_column,
                         cmd_bus.cell_char);
    if (cfg_bus.valid && cfg_bus.ready)
      board.set_back_porch(cfg_bus.back_porch_lines);
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      glyph_bus.ready <= 1'b0;
    end else begin
      glyph_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_command(input logic [1:0] op, input logic [4:0] row,
                              input logic [4:0] col, input logic [7:0] ch);
    while ($urandom_range(99) < idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_bus.valid       <= 1'b1;
    cmd_bus.command     <= op;
    cmd_bus.cell_row    <= row;
    cmd_bus.cell_column <= col;
    cmd_bus.cell_char   <= ch;
    @(posedge clk_i);
    while (!cmd_bus.ready) @(posedge clk_i);
  endtask

  // stop sending and wait for every expected fetch, then let the block go quiet
  task automatic drain_fetches(input int quiet);
    cmd_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (quiet) @(posedge clk_i);
  endtask

  task automatic write_back_porch(input logic [7:0] lines_in);
    drain_fetches(QUIET_CYCLES);
    cfg_bus.valid            <= 1'b1;
    cfg_bus.back_porch_lines <= lines_in;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic random_items(input int count);
    int pick;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 3) drain_fetches(0);
      pick = $urandom_range(99);
      if (pick < 40)
        send_command(tmgf_pkg::CMD_WRITE, 5'($urandom_range(TEXT_ROWS - 1)),
                     5'($urandom_range(COLS - 1)), 8'($urandom));
      else if (pick < 47)
        send_command(tmgf_pkg::CMD_WRITE, 5'($urandom), 5'($urandom), 8'($urandom));
      else if (pick < 94)
        send_command(tmgf_pkg::CMD_HSYNC, 5'($urandom), 5'($urandom), 8'($urandom));
      else if (pick < 97)
        send_command(tmgf_pkg::CMD_VSYNC, 5'($urandom), 5'($urandom), 8'($urandom));
      else
        send_command(CMD_UNUSED, 5'($urandom), 5'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int waited;
    rst_ni                   = 1'b0;
    cmd_bus.valid            = 1'b0;
    cmd_bus.command          = tmgf_pkg::CMD_WRITE;
    cmd_bus.cell_row         = 5'd0;
    cmd_bus.cell_column      = 5'd0;
    cmd_bus.cell_char        = 8'd0;
    cfg_bus.valid            = 1'b0;
    cfg_bus.back_porch_lines = tmgf_pkg::BACK_PORCH_RESET;
    glyph_bus.ready          = 1'b0;
    idle_pct                 = 0;
    stall_pct                = 0;
    hold_len                 = 0;
    hold_req                 = 0;
    hold_seen                = 0;
    hold_left                = 0;
    cycle_count              = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // hsync straight out of reset: no porch, line 0 of an empty store
    send_command(tmgf_pkg::CMD_HSYNC, 5'd0, 5'd0, 8'd0);
    send_command(tmgf_pkg::CMD_WRITE, 5'd0, 5'd0, 8'hFF);
    send_command(tmgf_pkg::CMD_WRITE, 5'd0, 5'd19, 8'h80);
    send_command(tmgf_pkg::CMD_WRITE, 5'd29, 5'd19, 8'h7F);
    send_command(tmgf_pkg::CMD_WRITE, 5'd29, 5'd0, 8'h01);
    send_command(tmgf_pkg::CMD_WRITE, 5'd30, 5'd0, 8'h55);
    send_command(tmgf_pkg::CMD_WRITE, 5'd31, 5'd31, 8'hAA);
    send_command(tmgf_pkg::CMD_WRITE, 5'd0, 5'd20, 8'h33);
    send_command(tmgf_pkg::CMD_WRITE, 5'd5, 5'd31, 8'hCC);
    send_command(CMD_UNUSED, 5'd31, 5'd31, 8'hFF);
    send_command(tmgf_pkg::CMD_HSYNC, 5'd31, 5'd31, 8'hFF);
    send_command(tmgf_pkg::CMD_HSYNC, 5'd0, 5'd0, 8'd0);
    send_command(tmgf_pkg::CMD_WRITE, 5'd0, 5'd0, 8'h00);
    send_command(tmgf_pkg::CMD_VSYNC, 5'd0, 5'd0, 8'd0);
    // porch from the reset value, then two active lines
    repeat (37) send_command(tmgf_pkg::CMD_HSYNC, 5'd0, 5'd0, 8'd0);

    write_back_porch(8'd0);
    send_command(tmgf_pkg::CMD_VSYNC, 5'd0, 5'd0, 8'd0);
    repeat (2) send_command(tmgf_pkg::CMD_HSYNC, 5'd0, 5'd0, 8'd0);

    // widest porch: these hsyncs all fall inside it
    write_back_porch(8'd255);
    send_command(tmgf_pkg::CMD_VSYNC, 5'd0, 5'd0, 8'd0);
    repeat (4) send_command(tmgf_pkg::CMD_HSYNC, 5'($urandom), 5'($urandom), 8'($urandom));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 68; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 68; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      write_back_porch(8'($urandom_range(6)));
      send_command(tmgf_pkg::CMD_VSYNC, 5'd0, 5'd0, 8'd0);
      random_items(75);
    end

    // two text rows of lines, receiver held off at the start
    idle_pct = 0;
    stall_pct = 21;
    write_back_porch(8'd3);
    send_command(tmgf_pkg::CMD_VSYNC, 5'd0, 5'd0, 8'd0);
    hold_len = 400;
    hold_req = hold_req + 1;
    for (int k = 0; k < 3 + 2 * tmgf_pkg::LINES_PER_TEXT_ROW; k++) begin
      if (k % 6 == 0)
        send_command(tmgf_pkg::CMD_WRITE, 5'($urandom_range(TEXT_ROWS - 1)),
                     5'($urandom_range(COLS - 1)), 8'($urandom));
      send_command(tmgf_pkg::CMD_HSYNC, 5'($urandom), 5'($urandom), 8'($urandom));
    end

    cmd_bus.valid <= 1'b0;
    waited = 0;
    while (board.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (QUIET_CYCLES) @(posedge clk_i);
    if (board.pending() != 0) begin
      $error("%0d expected fetch beats never arrived", board.pending());
      board.errors++;
    end

    $display("ran %0d commands: %0d cell writes, %0d vsyncs, %0d porch lines, %0d active lines",
             board.n_commands, board.n_writes, board.n_vsyncs, board.n_porch,
             board.n_lines);
    $display("checked %0d fetch beats across porch settings 0 to 255, %0d mismatches",
             board.n_checked, board.errors);
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
